@@ hdl/sitda_pkg.sv @@
`default_nettype none

package sitda_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int CHAR_W          = 6;
  localparam int OUT_TDATA_W     = 8;

  localparam logic [CHAR_W-1:0] MINUS_CODE = 6'd45;
  localparam logic [CHAR_W-1:0] DIGIT_BASE = 6'd48;

  // Operation applied to every BCD cell of the row at once.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_DABBLE,
    CELL_SHIFT
  } cell_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_DIGIT
  } state_e;

  // Decimal digits needed for a magnitude of up to 2^w - 1, enough for 2^(w-1).
  // 1233/4096 approximates log10(2).
  function automatic int num_digits(input int w);
    return ((w * 1233) >> 12) + 1;
  endfunction

endpackage

`default_nettype wire

@@ hdl/sitda_cell.sv @@
`default_nettype none

module sitda_cell (
  input  wire                clk_i,
  input  sitda_pkg::cell_op_e op_i,
  input  wire                bit_i,
  input  wire  [3:0]         digit_i,
  output logic               carry_o,
  output logic [3:0]         digit_o
);
  import sitda_pkg::*;

  logic [3:0] digit_q, digit_d;
  logic [3:0] adj;

  always_comb begin
    adj     = (digit_q >= 4'd5) ? (digit_q + 4'd3) : digit_q;
    carry_o = adj[3];
    digit_o = digit_q;
  end

  always_comb begin
    case (op_i)
      CELL_HOLD:   digit_d = digit_q;
      CELL_CLEAR:  digit_d = 4'd0;
      CELL_DABBLE: digit_d = {adj[2:0], bit_i};
      CELL_SHIFT:  digit_d = digit_i;
      default:     digit_d = digit_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

endmodule

`default_nettype wire

@@ hdl/signed_int_to_decimal_ascii.sv @@
// Signed integer to decimal ASCII converter. Each transaction on the slave
// stream carries one two's complement integer of VALUE_WIDTH bits in tdata
// (bits above VALUE_WIDTH are ignored). The block answers with one master
// transaction per character: tdata[5:0] holds the ASCII code ('-' or '0'..'9'),
// tlast marks the final character. A negative value starts with '-', leading
// zeros are dropped, zero gives a single '0', and the most negative value is
// converted exactly. Conversion runs in a row of BCD cells (shift-and-add-3),
// one input bit per cycle. Each item passes through these steps in order:
// accept, bit-serial conversion of all VALUE_WIDTH bits, skipping of the
// leading zeros, the minus sign for a negative value, and one digit after
// another; the sign and each digit wait while the output stalls. A new item
// is taken once the last character has entered the output register, while
// that character still waits to be taken.
`default_nettype none

module signed_int_to_decimal_ascii #(
  parameter int VALUE_WIDTH = sitda_pkg::VALUE_WIDTH_DEF
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // fields: value [VALUE_WIDTH-1:0], zero padded to whole bytes
  input  wire  [((VALUE_WIDTH+7)/8)*8-1:0]   s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  wire                                m_axis_tready_i,
  // fields: ascii_char [5:0], zeros above
  output logic [sitda_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,
  // last_char
  output logic                               m_axis_tlast_o
);
  import sitda_pkg::*;

  localparam int NDIG = num_digits(VALUE_WIDTH);
  localparam int BCW  = $clog2(VALUE_WIDTH + 1);
  localparam int DCW  = $clog2(NDIG + 1);

  state_e state_q, state_d;

  logic [VALUE_WIDTH-1:0] raw;
  logic [VALUE_WIDTH-1:0] mag_q, mag_d;
  logic                   neg_q, neg_d;
  logic [BCW-1:0]         bit_cnt_q, bit_cnt_d;
  logic [DCW-1:0]         dig_cnt_q, dig_cnt_d;

  logic              out_valid_q, out_valid_d;
  logic [CHAR_W-1:0] out_char_q, out_char_d;
  logic              out_last_q, out_last_d;

  cell_op_e   cell_op;
  logic       carry [NDIG];
  logic [3:0] digit [NDIG];
  logic [3:0] top_digit;

  logic in_fire;
  logic out_free;

  assign raw       = s_axis_tdata_i[VALUE_WIDTH-1:0];
  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign top_digit = digit[NDIG-1];

  // Row of BCD cells: cell 0 is the least significant digit. During
  // conversion each cell passes its carry up; during the leading-zero skip
  // and emission each cell takes the digit of its lower neighbor so the top
  // cell always shows the next digit to send.
  for (genvar i = 0; i < NDIG; i++) begin : g_cell
    logic       bit_in;
    logic [3:0] low_digit;
    if (i == 0) begin : g_first
      assign bit_in    = mag_q[VALUE_WIDTH-1];
      assign low_digit = 4'd0;
    end else begin : g_rest
      assign bit_in    = carry[i-1];
      assign low_digit = digit[i-1];
    end
    sitda_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_op),
      .bit_i   (bit_in),
      .digit_i (low_digit),
      .carry_o (carry[i]),
      .digit_o (digit[i])
    );
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) state_d = ST_CONV;
      end
      ST_CONV: begin
        if (bit_cnt_q == BCW'(1)) state_d = ST_SKIP;
      end
      ST_SKIP: begin
        // Advance past leading zeros, keeping at least one digit.
        if (!(top_digit == 4'd0 && dig_cnt_q > DCW'(1))) begin
          state_d = neg_q ? ST_SIGN : ST_DIGIT;
        end
      end
      ST_SIGN: begin
        if (out_free) state_d = ST_DIGIT;
      end
      ST_DIGIT: begin
        if (out_free && dig_cnt_q == DCW'(1)) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath control and outputs.
  always_comb begin
    s_axis_tready_o = (state_q == ST_IDLE);
    cell_op     = CELL_HOLD;
    mag_d       = mag_q;
    neg_d       = neg_q;
    bit_cnt_d   = bit_cnt_q;
    dig_cnt_d   = dig_cnt_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          // Take the magnitude as unsigned so the most negative value fits.
          neg_d     = raw[VALUE_WIDTH-1];
          mag_d     = raw[VALUE_WIDTH-1] ? (~raw + VALUE_WIDTH'(1)) : raw;
          bit_cnt_d = BCW'(VALUE_WIDTH);
          cell_op   = CELL_CLEAR;
        end
      end
      ST_CONV: begin
        cell_op   = CELL_DABBLE;
        mag_d     = {mag_q[VALUE_WIDTH-2:0], 1'b0};
        bit_cnt_d = bit_cnt_q - BCW'(1);
        dig_cnt_d = DCW'(NDIG);
      end
      ST_SKIP: begin
        if (top_digit == 4'd0 && dig_cnt_q > DCW'(1)) begin
          cell_op   = CELL_SHIFT;
          dig_cnt_d = dig_cnt_q - DCW'(1);
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = MINUS_CODE;
          out_last_d  = 1'b0;
        end
      end
      ST_DIGIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = DIGIT_BASE + {2'b00, top_digit};
          out_last_d  = (dig_cnt_q == DCW'(1));
          cell_op     = CELL_SHIFT;
          dig_cnt_d   = dig_cnt_q - DCW'(1);
        end
      end
      default: begin
        cell_op = CELL_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      bit_cnt_q   <= '0;
      dig_cnt_q   <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      bit_cnt_q   <= bit_cnt_d;
      dig_cnt_q   <= dig_cnt_d;
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk_i) begin
    mag_q      <= mag_d;
    neg_q      <= neg_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OUT_TDATA_W-CHAR_W)'(0), out_char_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule

`default_nettype wire

@@ hdl/sitda_checker.sv @@
`default_nettype none

module sitda_checker #(
  parameter int VALUE_WIDTH = sitda_pkg::VALUE_WIDTH_DEF
) (
  input wire                               clk_i,
  input wire                               rst_ni,
  input wire                               s_axis_tvalid_i,
  input wire                               s_axis_tready_o,
  input wire [((VALUE_WIDTH+7)/8)*8-1:0]   s_axis_tdata_i,
  input wire                               m_axis_tvalid_o,
  input wire                               m_axis_tready_i,
  input wire [sitda_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,
  input wire                               m_axis_tlast_o
);
  import sitda_pkg::*;

  logic [CHAR_W-1:0] ch;
  assign ch = m_axis_tdata_o[CHAR_W-1:0];

  // Only a minus sign or a decimal digit leaves the block.
  a_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (ch == MINUS_CODE ||
                         (ch >= DIGIT_BASE && ch <= DIGIT_BASE + 6'd9)))
    else $error("illegal character code");

  // A minus sign is always followed by digits.
  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && ch == MINUS_CODE) |-> !m_axis_tlast_o)
    else $error("minus sign flagged as last");

  // An accepted item is converted before another is taken.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input accepted during conversion");

  // Hold a stalled character.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o)))
    else $error("stalled output changed");

endmodule

bind signed_int_to_decimal_ascii sitda_checker #(
  .VALUE_WIDTH (VALUE_WIDTH)
) u_sitda_checker (.*);

`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import sitda_pkg::*;

  localparam int VW        = VALUE_WIDTH_DEF;
  localparam int IN_W      = ((VW + 7) / 8) * 8;
  localparam int RAND_N    = 400;
  localparam int HOLD_CYC  = 300;
  localparam int DRAIN_CYC = 80;

  // One expected character of a decimal run.
  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } ascii_char_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_W-1:0]        s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  ascii_char_t pending_chars[$];
  int          mismatch_cnt;
  bit          no_idle;
  bit          hold_req;

  // Directed rows: value and, where obvious, the text it must produce.
  logic [VW-1:0] dir_value_q[$];
  string         dir_text_q[$];

  signed_int_to_decimal_ascii #(
    .VALUE_WIDTH(VW)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("tb NOT OK");
    $finish;
  end

  // Idle length: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Expand a value into its decimal characters, sign first.
  task automatic queue_decimal_text(input logic [VW-1:0] value);
    logic [VW-1:0] mag;
    logic [3:0]    digits[0:19];
    ascii_char_t   c;
    int            nd;
    int            i;
    mag = value[VW-1] ? (~value + 1'b1) : value;
    nd  = 0;
    do begin
      digits[nd] = 4'(mag % 10);
      mag        = mag / 10;
      nd++;
    end while (mag != 0);
    if (value[VW-1]) begin
      c.code = MINUS_CODE;
      c.last = 1'b0;
      pending_chars.push_back(c);
    end
    for (i = nd - 1; i >= 0; i--) begin
      c.code = DIGIT_BASE + CHAR_W'(digits[i]);
      c.last = (i == 0);
      pending_chars.push_back(c);
    end
  endtask

  task automatic queue_literal_text(input string text);
    ascii_char_t c;
    byte         b;
    for (int i = 0; i < text.len(); i++) begin
      b      = text[i];
      c.code = b[CHAR_W-1:0];
      c.last = (i == text.len() - 1);
      pending_chars.push_back(c);
    end
  endtask

  // Offer one value after a random gap; hold it until the block takes it.
  // An empty text means the predictor supplies the expected characters.
  task automatic send_value(input logic [VW-1:0] value, input string text);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= $urandom;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'(value);
    do @(posedge clk_i); while (!s_axis_tready);
    if (text.len() == 0) queue_decimal_text(value);
    else queue_literal_text(text);
  endtask

  task automatic add_row(input logic [VW-1:0] value, input string text);
    dir_value_q.push_back(value);
    dir_text_q.push_back(text);
  endtask

  // Random values weighted toward digit-count boundaries and the extremes.
  function automatic logic [VW-1:0] pick_value();
    logic [VW-1:0] v;
    logic [VW-1:0] p;
    int            k;
    case ($urandom_range(0, 9))
      4: v = VW'($urandom_range(0, 40)) - VW'(20);
      5: begin
        k = $urandom_range(0, 9);
        p = 1;
        repeat (k) p = p * 10;
        v = p + VW'($urandom_range(0, 2)) - VW'(1);
        if ($urandom_range(0, 1)) v = -v;
      end
      6: begin
        if ($urandom_range(0, 1)) v = {1'b0, {(VW-1){1'b1}}} - VW'($urandom_range(0, 3));
        else v = {1'b1, {(VW-1){1'b0}}} + VW'($urandom_range(0, 3));
      end
      7: begin
        v = VW'($urandom_range(0, 99999));
        if ($urandom_range(0, 1)) v = -v;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int n;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        repeat (HOLD_CYC) begin
          @(negedge clk_i);
          m_axis_tready <= 1'b0;
        end
      end else begin
        n = pick_gap();
        repeat (n) begin
          @(negedge clk_i);
          m_axis_tready <= 1'b0;
        end
        n = $urandom_range(1, 12);
        repeat (n) begin
          @(negedge clk_i);
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  // Compare each character transaction against the oldest expectation.
  always @(posedge clk_i) begin
    ascii_char_t exp_c;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_chars.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("%0t: unexpected char tdata=%0d tlast=%0b", $realtime,
                   m_axis_tdata, m_axis_tlast);
      end else begin
        exp_c = pending_chars.pop_front();
        if (m_axis_tdata !== OUT_TDATA_W'(exp_c.code) || m_axis_tlast !== exp_c.last) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: char exp %0d/last %0b, got %0d/last %0b", $realtime,
                     exp_c.code, exp_c.last, m_axis_tdata, m_axis_tlast);
        end
      end
    end
  end

  initial begin
    int n_drain;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    mismatch_cnt  = 0;
    no_idle       = 1'b0;
    hold_req      = 1'b0;
    rst_ni        = 1'b0;

    add_row(32'd0,           "0");
    add_row(32'd1,           "1");
    add_row(-32'sd1,         "-1");
    add_row(32'd9,           "9");
    add_row(32'd10,          "10");
    add_row(-32'sd10,        "-10");
    add_row(32'd2147483647,  "2147483647");
    add_row(32'h8000_0000,   "-2147483648");
    add_row(-32'sd2147483647, "-2147483647");
    add_row(32'd1000000000,  "1000000000");
    add_row(-32'sd1000000000, "-1000000000");
    add_row(32'd123456789,   "123456789");
    add_row(-32'sd7,         "-7");
    add_row(32'd999999999,   "");
    add_row(32'd100,         "");
    add_row(32'h5555_5555,   "");
    add_row(32'hAAAA_AAAA,   "");
    add_row(32'h0000_FFFF,   "");
    add_row(32'hFFFF_0000,   "");
    add_row(32'h0000_0080,   "");

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < dir_value_q.size(); i++) send_value(dir_value_q[i], dir_text_q[i]);

    for (int i = 0; i < RAND_N; i++) begin
      // Run back to back for a while, then fill the block against a
      // stalled receiver, and later drain it completely before going on.
      if (i == 100) no_idle = 1'b1;
      if (i == 160) no_idle = 1'b0;
      if (i == 200) hold_req = 1'b1;
      if (i == 300) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        wait (pending_chars.size() == 0);
      end
      send_value(pick_value(), "");
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    wait (pending_chars.size() == 0);
    n_drain = DRAIN_CYC;
    repeat (n_drain) @(posedge clk_i);

    if (mismatch_cnt == 0 && pending_chars.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
